FILE: hw/rtl/tkok_pkg.sv
// Package for the top-k orientation keeper: widths, commands, payload types
// and the quarter-wave sine function used to build the trig table.
// No dependencies.
`default_nettype none
package tkok_pkg;

    localparam int MAX_KEEP_DEF        = 16;
    localparam int TRIG_TABLE_BITS_DEF = 10;
    localparam int FULL_TURN           = 23040;
    localparam int HALF_TURN           = 11520;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [3:0] REG_KEEP_COUNT = 4'd0;
    localparam logic [3:0] REG_PIX_PITCH  = 4'd1;

    typedef struct packed {
        logic [3:0]         read_rank;
        logic               mirrored;
        logic signed [15:0] peak_y;
        logic signed [15:0] peak_x;
        logic [14:0]        inplane_angle;
        logic [13:0]        view_theta;
        logic [14:0]        view_phi;
        logic signed [31:0] score;
        logic [1:0]         command;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_x;
        logic [14:0]        psi;
        logic [15:0]        theta;
        logic [14:0]        phi;
        logic signed [31:0] score;
    } entry_t;

    typedef struct packed {
        cmd_t       command;
        logic [3:0] read_rank;
        entry_t     cand;
    } work_t;

    typedef struct packed {
        logic               accepted;
        logic [3:0]         placed_rank;
        entry_t             ent;
    } result_t;

    // Quarter-wave sine in Q1.14; r in 0..2**qbits.
    function automatic logic signed [15:0] quarter_sin(input logic [63:0] r,
                                                       input int qbits);
        logic [63:0] x, x2, t;
        x  = (r * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        return 16'(((((x * t) >> 30) + 64'd32768) >> 16));
    endfunction

    function automatic logic signed [15:0] sin_entry(input int k, input int tbits);
        logic [63:0] n, quarter, q, r, kk;
        logic signed [15:0] v;
        n = 64'd1 << tbits;
        quarter = n >> 2;
        kk = 64'(k) & (n - 64'd1);
        q = kk >> (tbits - 2);
        r = kk & (quarter - 64'd1);
        if (q == 64'd0) v = quarter_sin(r, tbits - 2);
        else if (q == 64'd1) v = quarter_sin(quarter - r, tbits - 2);
        else if (q == 64'd2) v = -quarter_sin(r, tbits - 2);
        else v = -quarter_sin(quarter - r, tbits - 2);
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/top_k_orientation_keeper.sv
// Top level of the top-k orientation keeper: configuration registers, front
// end, queue and list engine. Depends on tkok_pkg and the tkok_* modules.
//
// A clear, a read or a rejected offer passes from the input transaction to
// the result transaction through five front-end steps (index, table lookup,
// multiply, scale, push), the queue and the list engine. An accepted offer
// also climbs one rank for each swap in the list engine, which moves it one
// swap per cycle. The front end takes no new transaction until the last one
// has been pushed, and it waits while the queue is full; a stalled result stalls
// the list engine, then the queue, then the input.
`default_nettype none
module top_k_orientation_keeper #(
    parameter int TRIG_TABLE_BITS = tkok_pkg::TRIG_TABLE_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command, score, view_phi, view_theta, inplane_angle, peak_x, peak_y,
    // mirrored, read_rank (lowest bits first), zero fill to 120
    input  wire logic [119:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted, placed_rank, out_score, out_phi, out_theta, out_psi,
    // out_shift_x, out_shift_y (lowest bits first), zero fill to 152
    output logic [151:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    logic [4:0] keep_count_reg;
    logic [15:0] pix_pitch_reg;
    logic q_push, q_full, q_pop, q_ne;
    tkok_pkg::work_t q_in, q_out;
    tkok_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            keep_count_reg <= 5'd1;
            pix_pitch_reg <= 16'd256;
        end else if (cfg_we) begin
            if (cfg_index == tkok_pkg::REG_KEEP_COUNT) keep_count_reg <= cfg_data[4:0];
            else if (cfg_index == tkok_pkg::REG_PIX_PITCH) pix_pitch_reg <= cfg_data;
        end
    end

    tkok_front #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(tkok_pkg::in_item_t'(s_tdata[114:0])), .pix_pitch(pix_pitch_reg),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    tkok_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .not_empty(q_ne)
    );

    tkok_list u_list (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_out), .q_pop(q_pop),
        .keep_count(keep_count_reg), .res_valid(m_tvalid), .res_ready(m_tready),
        .res(res)
    );

    assign m_tdata = {5'd0, res.ent.shift_y, res.ent.shift_x, res.ent.psi,
                      res.ent.theta, res.ent.phi, res.ent.score,
                      res.placed_rank, res.accepted};
endmodule
`default_nettype wire

FILE: hw/rtl/tkok_front.sv
// Front end: accepts transactions, computes the rotated and scaled shift
// over a few registered steps, and pushes the finished work into a queue.
// Depends on tkok_pkg.
`default_nettype none
module tkok_front #(
    parameter int TRIG_TABLE_BITS = tkok_pkg::TRIG_TABLE_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tkok_pkg::in_item_t in_item,
    input  wire logic [15:0]       pix_pitch,
    output logic                   q_push,
    output tkok_pkg::work_t        q_data,
    input  wire logic              q_full
);
    localparam int N = 1 << TRIG_TABLE_BITS;
    localparam int IW = TRIG_TABLE_BITS;
    localparam int NUM_W = 15 + IW;
    localparam int RSH = NUM_W + 15;
    localparam logic [63:0] RECIP = ((64'd1 << RSH) + 64'(tkok_pkg::FULL_TURN) - 64'd1)
                                    / 64'(tkok_pkg::FULL_TURN);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INDEX = 6'b000010,
        S_LOOK  = 6'b000100,
        S_MUL   = 6'b001000,
        S_SCALE = 6'b010000,
        S_PUSH  = 6'b100000
    } fstate_t;

    fstate_t state_reg, state_next;
    tkok_pkg::in_item_t item_reg;
    logic [IW-1:0] idx_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic signed [33:0] vx_reg, vy_reg;
    logic signed [31:0] sx_reg, sy_reg;

    logic signed [15:0] sin_tab [N];
    for (genvar g = 0; g < N; g++) begin : g_tab
        assign sin_tab[g] = tkok_pkg::sin_entry(g, TRIG_TABLE_BITS);
    end

    logic [14:0] psi_mod;
    logic [NUM_W-1:0] idx_num;
    logic [63:0] idx_prod;
    logic [IW-1:0] idx_cos;
    logic signed [31:0] pxc, pys, pxs, pyc;
    logic signed [33:0] vx_c, vy_c;
    logic signed [50:0] px_prod, py_prod;

    function automatic logic signed [31:0] scale(input logic signed [50:0] v);
        logic [50:0] mag;
        logic [50:0] m;
        logic signed [51:0] sm;
        mag = v[50] ? 51'(-v) : 51'(v);
        m = (mag + 51'(1 << 21)) >> 22;
        sm = v[50] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (sm > 52'sd2147483647) return 32'h7FFFFFFF;
        if (sm < -52'sd2147483648) return 32'h80000000;
        return sm[31:0];
    endfunction

    always_comb begin
        psi_mod = (item_reg.inplane_angle >= 15'(tkok_pkg::FULL_TURN))
                ? item_reg.inplane_angle - 15'(tkok_pkg::FULL_TURN)
                : item_reg.inplane_angle;
        idx_num = (NUM_W'(psi_mod) << IW) + NUM_W'(tkok_pkg::HALF_TURN);
        idx_prod = 64'(idx_num) * RECIP;
        idx_cos = idx_reg + IW'(N / 4);
        pxc = item_reg.peak_x * cos_reg;
        pys = item_reg.peak_y * sin_reg;
        pxs = item_reg.peak_x * sin_reg;
        pyc = item_reg.peak_y * cos_reg;
        if (item_reg.mirrored) begin
            vx_c = 34'(pxc) - 34'(pys);
            vy_c = -34'(pxs) - 34'(pyc);
        end else begin
            vx_c = -34'(pxc) - 34'(pys);
            vy_c = 34'(pxs) - 34'(pyc);
        end
        px_prod = 51'(vx_reg) * $signed({1'b0, pix_pitch});
        py_prod = 51'(vy_reg) * $signed({1'b0, pix_pitch});
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_INDEX;
            S_INDEX: state_next = S_LOOK;
            S_LOOK:  state_next = S_MUL;
            S_MUL:   state_next = S_SCALE;
            S_SCALE: state_next = S_PUSH;
            S_PUSH:  if (!q_full) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign q_push = (state_reg == S_PUSH) && !q_full;

    always_comb begin
        q_data.command = tkok_pkg::cmd_t'(item_reg.command);
        q_data.read_rank = item_reg.read_rank;
        q_data.cand.score = item_reg.score;
        q_data.cand.phi = item_reg.view_phi;
        q_data.cand.theta = item_reg.mirrored
                          ? 16'(item_reg.view_theta) + 16'(tkok_pkg::HALF_TURN)
                          : 16'(item_reg.view_theta);
        q_data.cand.psi = item_reg.inplane_angle;
        q_data.cand.shift_x = sx_reg;
        q_data.cand.shift_y = sy_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) item_reg <= in_item;
        if (state_reg == S_INDEX) begin
            idx_reg <= idx_prod[RSH+IW-1:RSH];
        end
        if (state_reg == S_MUL) begin
            vx_reg <= vx_c;
            vy_reg <= vy_c;
        end
        if (state_reg == S_SCALE) begin
            sx_reg <= scale(px_prod);
            sy_reg <= scale(py_prod);
        end
    end

    always_ff @(posedge clk) begin
        sin_reg <= sin_tab[idx_reg];
        cos_reg <= sin_tab[idx_cos];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tkok_queue.sv
// Two-entry queue between the front end and the list engine.
// Depends on tkok_pkg.
`default_nettype none
module tkok_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tkok_pkg::work_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output tkok_pkg::work_t      pop_data,
    output logic                 not_empty
);
    tkok_pkg::work_t mem_reg [2];
    logic rd_ptr_reg, wr_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tkok_list.sv
// List engine: clears, inserts with one swap per cycle, reads by rank, and
// holds the result in an output register.
// Depends on tkok_pkg.
`default_nettype none
module tkok_list (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire tkok_pkg::work_t q_data,
    output logic                 q_pop,
    input  wire logic [4:0]      keep_count,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output tkok_pkg::result_t    res
);
    localparam int MAX_KEEP = tkok_pkg::MAX_KEEP_DEF;
    localparam int RW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_SORT = 3'b010,
        L_DONE = 3'b100
    } lstate_t;

    lstate_t state_reg, state_next;
    tkok_pkg::entry_t ent_reg [MAX_KEEP];
    tkok_pkg::entry_t empty_ent;
    logic [RW-1:0] pos_reg, last_pos;
    logic [4:0] k_eff;
    logic [4:0] rank_ext;
    logic accept;
    logic can_start;
    tkok_pkg::result_t res_next;

    always_comb begin
        empty_ent = '0;
        empty_ent.score = 32'sh80000000;
        if (keep_count == 5'd0) k_eff = 5'd1;
        else if (32'(keep_count) > MAX_KEEP) k_eff = 5'(MAX_KEEP);
        else k_eff = keep_count;
        last_pos = RW'(k_eff - 5'd1);
        rank_ext = {1'b0, q_data.read_rank};
        accept = q_data.cand.score > ent_reg[last_pos].score;
        can_start = (state_reg == L_IDLE) && q_valid && !res_valid;
        q_pop = can_start;
    end

    always_comb begin
        res_next = '0;
        unique case (q_data.command)
            tkok_pkg::CMD_OFFER: begin
                res_next.ent = q_data.cand;
                res_next.accepted = accept;
            end
            tkok_pkg::CMD_READ: begin
                if (rank_ext < k_eff && 32'(q_data.read_rank) < MAX_KEEP)
                    res_next.ent = ent_reg[RW'(q_data.read_rank)];
                else
                    res_next.ent = empty_ent;
            end
            tkok_pkg::CMD_CLEAR, tkok_pkg::CMD_NONE: res_next = '0;
            default: res_next = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (can_start) state_next =
                (q_data.command == tkok_pkg::CMD_OFFER && accept) ? L_SORT : L_DONE;
            L_SORT: if (pos_reg == '0 ||
                        !(ent_reg[pos_reg].score > ent_reg[pos_reg - RW'(1)].score))
                        state_next = L_DONE;
            L_DONE: state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= L_IDLE;
            res_valid <= 1'b0;
            res <= '0;
            pos_reg <= '0;
            for (int i = 0; i < MAX_KEEP; i++) ent_reg[i] <= empty_ent;
        end else begin
            state_reg <= state_next;
            if (res_valid && res_ready) res_valid <= 1'b0;
            if (state_reg == L_DONE) begin
                res_valid <= 1'b1;
                res.placed_rank <= res.accepted ? 4'(pos_reg) : 4'd0;
            end
            if (can_start) begin
                res.accepted <= res_next.accepted;
                res.ent <= res_next.ent;
                pos_reg <= last_pos;
                if (q_data.command == tkok_pkg::CMD_CLEAR)
                    for (int i = 0; i < MAX_KEEP; i++) ent_reg[i] <= empty_ent;
                if (q_data.command == tkok_pkg::CMD_OFFER && accept)
                    ent_reg[last_pos] <= q_data.cand;
            end
            if (state_reg == L_SORT && pos_reg != '0 &&
                ent_reg[pos_reg].score > ent_reg[pos_reg - RW'(1)].score) begin
                ent_reg[pos_reg] <= ent_reg[pos_reg - RW'(1)];
                ent_reg[pos_reg - RW'(1)] <= ent_reg[pos_reg];
                pos_reg <= pos_reg - RW'(1);
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tkok_checker.sv
// Port-level checker for the top-k orientation keeper, bound to the top.
// Depends on the top level's ports only.
`default_nettype none
module tkok_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [151:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("rank without acceptance");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken at once");
endmodule

bind top_k_orientation_keeper tkok_checker u_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

FILE: tb/top_k_orientation_keeper_tb.sv
// Self-checking testbench for top_k_orientation_keeper: directed table, then random
// clear/offer/read/no-op transactions checked against an in-bench model of the sorted list.
// Depends on tkok_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module top_k_orientation_keeper_tb;

    typedef struct packed {
        logic               accepted;
        logic [3:0]         placed_rank;
        logic signed [31:0] score;
        logic [14:0]        phi;
        logic [15:0]        theta;
        logic [14:0]        psi;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
    } orient_res_t;

    typedef struct {
        bit                 is_cfg;
        logic [3:0]         cfg_idx;
        logic [15:0]        cfg_val;
        tkok_pkg::in_item_t item;
        bit                 typed;
        orient_res_t        want;
    } stim_row_t;

    localparam logic signed [31:0] SCORE_FLOOR = 32'sh8000_0000;
    localparam int DRAIN_CYCLES = 40;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [3:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    logic signed [31:0] list_score [16];
    logic [14:0]        list_phi [16];
    logic [15:0]        list_theta [16];
    logic [14:0]        list_psi [16];
    logic signed [31:0] list_sx [16];
    logic signed [31:0] list_sy [16];
    logic [4:0]         keep_reg;
    logic [15:0]        pixel_reg;

    orient_res_t pending_results[$];
    bit          idle_on = 1'b1;
    int          mismatches = 0;
    int          n_offers = 0;
    int          n_placed = 0;
    int          n_reads = 0;
    int          n_clears = 0;
    int          n_results = 0;

    top_k_orientation_keeper u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint qsine(longint r);
        longint unsigned x, x2, t;
        x  = longint'(r) * 64'd1686629713 / 64'd256;
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        return longint'((((x * t) >> 30) + 64'd32768) >> 16);
    endfunction

    function automatic longint table_sine(int k);
        int idx, r;
        idx = k & 1023;
        r = idx % 256;
        case (idx / 256)
            0: return qsine(r);
            1: return qsine(256 - r);
            2: return -qsine(r);
            default: return -qsine(256 - r);
        endcase
    endfunction

    function automatic logic signed [31:0] to_angstrom(longint v);
        longint m;
        if (v >= 0) m = (v + (64'sd1 <<< 21)) >>> 22;
        else m = -((-v + (64'sd1 <<< 21)) >>> 22);
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        return m[31:0];
    endfunction

    function automatic int active_keep();
        if (keep_reg < 1) return 1;
        if (keep_reg > 16) return 16;
        return keep_reg;
    endfunction

    function automatic void wipe_list();
        for (int i = 0; i < 16; i++) begin
            list_score[i] = SCORE_FLOOR;
            list_phi[i] = '0;
            list_theta[i] = '0;
            list_psi[i] = '0;
            list_sx[i] = '0;
            list_sy[i] = '0;
        end
    endfunction

    function automatic orient_res_t predict_orientation(tkok_pkg::in_item_t it);
        orient_res_t r;
        longint px, py, s, c, vx, vy;
        int k, pos;
        logic signed [31:0] ts;
        logic [15:0] tt;
        logic [14:0] tp, tq;
        r = '0;
        case (tkok_pkg::cmd_t'(it.command))
            tkok_pkg::CMD_CLEAR: wipe_list();
            tkok_pkg::CMD_OFFER: begin
                px = it.peak_x;
                py = it.peak_y;
                k = ((int'(it.inplane_angle) % tkok_pkg::FULL_TURN) * 1024
                     + tkok_pkg::HALF_TURN) / tkok_pkg::FULL_TURN;
                s = table_sine(k);
                c = table_sine(k + 256);
                r.score = it.score;
                r.phi = it.view_phi;
                r.psi = it.inplane_angle;
                r.theta = {2'b00, it.view_theta};
                if (it.mirrored) begin
                    vx = px * c - py * s;
                    vy = -px * s - py * c;
                    r.theta = r.theta + 16'(tkok_pkg::HALF_TURN);
                end else begin
                    vx = -px * c - py * s;
                    vy = px * s - py * c;
                end
                r.shift_x = to_angstrom(vx * longint'(pixel_reg));
                r.shift_y = to_angstrom(vy * longint'(pixel_reg));
                pos = active_keep() - 1;
                if (r.score > list_score[pos]) begin
                    r.accepted = 1'b1;
                    list_score[pos] = r.score;
                    list_phi[pos] = r.phi;
                    list_theta[pos] = r.theta;
                    list_psi[pos] = r.psi;
                    list_sx[pos] = r.shift_x;
                    list_sy[pos] = r.shift_y;
                    while (pos > 0 && list_score[pos] > list_score[pos-1]) begin
                        ts = list_score[pos]; list_score[pos] = list_score[pos-1];
                        list_score[pos-1] = ts;
                        tq = list_phi[pos]; list_phi[pos] = list_phi[pos-1];
                        list_phi[pos-1] = tq;
                        tt = list_theta[pos]; list_theta[pos] = list_theta[pos-1];
                        list_theta[pos-1] = tt;
                        tp = list_psi[pos]; list_psi[pos] = list_psi[pos-1];
                        list_psi[pos-1] = tp;
                        ts = list_sx[pos]; list_sx[pos] = list_sx[pos-1]; list_sx[pos-1] = ts;
                        ts = list_sy[pos]; list_sy[pos] = list_sy[pos-1]; list_sy[pos-1] = ts;
                        pos--;
                    end
                    r.placed_rank = pos[3:0];
                end
            end
            tkok_pkg::CMD_READ: begin
                if (it.read_rank < active_keep()) begin
                    r.score = list_score[it.read_rank];
                    r.phi = list_phi[it.read_rank];
                    r.theta = list_theta[it.read_rank];
                    r.psi = list_psi[it.read_rank];
                    r.shift_x = list_sx[it.read_rank];
                    r.shift_y = list_sy[it.read_rank];
                end else begin
                    r.score = SCORE_FLOOR;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic orient_res_t unpack_result(logic [151:0] d);
        orient_res_t r;
        r.accepted = d[0];
        r.placed_rank = d[4:1];
        r.score = d[36:5];
        r.phi = d[51:37];
        r.theta = d[67:52];
        r.psi = d[82:68];
        r.shift_x = d[114:83];
        r.shift_y = d[146:115];
        return r;
    endfunction

    function automatic tkok_pkg::in_item_t make_item(tkok_pkg::cmd_t cmd,
                                                     logic signed [31:0] score,
                                                     int phi, int theta, int psi,
                                                     int px, int py, bit mir, int rank);
        tkok_pkg::in_item_t it;
        it.command = cmd;
        it.score = score;
        it.view_phi = phi[14:0];
        it.view_theta = theta[13:0];
        it.inplane_angle = psi[14:0];
        it.peak_x = px[15:0];
        it.peak_y = py[15:0];
        it.mirrored = mir;
        it.read_rank = rank[3:0];
        return it;
    endfunction

    always @(posedge clk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 25);
    end

    always @(posedge clk) begin
        orient_res_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            n_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result transaction %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result %0d mismatch", n_results);
                        $display("  exp acc=%0d rank=%0d score=%0d phi=%0d theta=%0d psi=%0d sx=%0d sy=%0d",
                                 want.accepted, want.placed_rank, want.score, want.phi,
                                 want.theta, want.psi, want.shift_x, want.shift_y);
                        $display("  got acc=%0d rank=%0d score=%0d phi=%0d theta=%0d psi=%0d sx=%0d sy=%0d",
                                 got.accepted, got.placed_rank, got.score, got.phi,
                                 got.theta, got.psi, got.shift_x, got.shift_y);
                    end
                end
            end
        end
    end

    task automatic send_item(tkok_pkg::in_item_t it, bit typed, orient_res_t want);
        orient_res_t r;
        while (idle_on && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, it};
        do @(posedge clk); while (!s_tready);
        r = predict_orientation(it);
        pending_results.push_back(typed ? want : r);
        case (tkok_pkg::cmd_t'(it.command))
            tkok_pkg::CMD_OFFER: begin n_offers++; n_placed += r.accepted; end
            tkok_pkg::CMD_READ:  n_reads++;
            tkok_pkg::CMD_CLEAR: n_clears++;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tkok_pkg::REG_KEEP_COUNT) keep_reg = val[4:0];
        else if (idx == tkok_pkg::REG_PIX_PITCH) pixel_reg = val;
    endtask

    task automatic random_item(int score_mode);
        tkok_pkg::in_item_t it;
        int sel;
        sel = $urandom_range(99);
        it = make_item(tkok_pkg::CMD_OFFER, $urandom, $urandom_range(23039),
                       $urandom_range(11519),
                       ($urandom_range(9) == 0) ? $urandom_range(32767)
                                                : $urandom_range(23039),
                       $urandom, $urandom, $urandom_range(1), $urandom_range(15));
        if (score_mode == 1) it.score = $signed($urandom_range(8)) - 4;
        else if (score_mode == 2) it.score = SCORE_FLOOR + $urandom_range(3);
        else if (score_mode == 3 && sel[0]) it.score = 32'sh7FFF_FFFF - $urandom_range(2);
        if (sel < 2) it.command = tkok_pkg::CMD_CLEAR;
        else if (sel < 5) it.command = tkok_pkg::CMD_NONE;
        else if (sel < 30) it.command = tkok_pkg::CMD_READ;
        send_item(it, 1'b0, '0);
    endtask

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        orient_res_t empty_rd;
        int phase_keep [6] = '{1, 16, 0, 31, 5, 9};
        int phase_pix [6] = '{256, 65535, 1, 300, 1, 4096};

        keep_reg = 5'd1;
        pixel_reg = 16'd256;
        wipe_list();
        empty_rd = '0;
        empty_rd.score = SCORE_FLOOR;

        row = '{default: '0};
        row.typed = 1'b1;
        row.want = empty_rd;
        row.item = make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 15);
        rows.push_back(row);
        row.want = '0;
        row.item = make_item(tkok_pkg::CMD_NONE, 32'sh7FFF_FFFF, 23039, 11519, 23039,
                             -1, -1, 1, 15);
        rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_item(tkok_pkg::CMD_OFFER, SCORE_FLOOR, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_OFFER, 32'sh7FFF_FFFF, 0, 0, 0,
                             32767, -32768, 0, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_OFFER, 32'sh7FFF_FFFF, 23039, 11519, 23039,
                             -32768, 32767, 1, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.typed = 1'b1;
        row.item = make_item(tkok_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.want = empty_rd;
        row.item = make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_idx = tkok_pkg::REG_KEEP_COUNT;
        row.cfg_val = 16'd16;
        rows.push_back(row);
        row.cfg_idx = tkok_pkg::REG_PIX_PITCH;
        row.cfg_val = 16'd65535;
        rows.push_back(row);
        row.is_cfg = 1'b0;
        row.item = make_item(tkok_pkg::CMD_OFFER, 100, 10, 20, 5760, 32767, 32767, 0, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_OFFER, 300, 11, 21, 32767, -32768, -32768, 1, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_OFFER, 200, 12, 22, 11520, 256, -256, 0, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_OFFER, 200, 13, 23, 17280, -256, 256, 1, 0);
        rows.push_back(row);
        row.item = make_item(tkok_pkg::CMD_OFFER, -5, 14, 24, 23039, 1, 1, 0, 0);
        rows.push_back(row);
        for (int i = 0; i < 5; i++) begin
            row.item = make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, i);
            rows.push_back(row);
        end
        row.item = make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 15);
        rows.push_back(row);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else send_item(rows[i].item, rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < 7; p++) begin
            if (p < 6) begin
                write_reg(tkok_pkg::REG_KEEP_COUNT, 16'(phase_keep[p]));
                write_reg(tkok_pkg::REG_PIX_PITCH, 16'(phase_pix[p]));
            end else begin
                write_reg(tkok_pkg::REG_KEEP_COUNT, 16'($urandom_range(31)));
                write_reg(tkok_pkg::REG_PIX_PITCH, 16'($urandom_range(65535)));
            end
            idle_on = (p != 2);
            send_item(make_item(tkok_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
            for (int n = 0; n < 120; n++) begin
                if (n % 40 == 39) begin
                    for (int rk = 0; rk < 16; rk++)
                        send_item(make_item(tkok_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, rk),
                                  1'b0, '0);
                end else begin
                    random_item((p + n / 40) % 4);
                end
            end
        end
        idle_on = 1'b1;
        drain_results();

        $display("Covered %0d offers (%0d entered the list), %0d reads and %0d clears,",
                 n_offers, n_placed, n_reads, n_clears);
        $display("over keep counts 0 to 31 and pixel sizes 1 to 65535; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("top_k_orientation_keeper_tb: PASS");
        else
            $display("top_k_orientation_keeper_tb: FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("ERROR: timeout with %0d results outstanding", pending_results.size());
        $display("top_k_orientation_keeper_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/tkok_pkg.sv
hw/rtl/tkok_front.sv
hw/rtl/tkok_queue.sv
hw/rtl/tkok_list.sv
hw/rtl/top_k_orientation_keeper.sv
hw/rtl/tkok_checker.sv
tb/top_k_orientation_keeper_tb.sv
